/* hdl/ccp_pkg.sv */
// Shared types, widths and helpers for the centered crop/pad address generator.
// Used by ccp_cell and center_crop_pad_address_gen; no dependencies.
package ccp_pkg;

    localparam int SIZE_W       = 13;
    localparam int COORD_W      = 12;
    localparam int IDX_W        = 48;
    localparam int NUM_REG_AXES = 4;
    localparam int CFG_IDX_W    = 4;

    localparam logic [SIZE_W-1:0] MAX_SIZE = 13'd4096;
    localparam logic [SIZE_W-1:0] SIZE_ONE = 13'd1;

    // Register index bases: input sizes first, then output sizes
    localparam logic [CFG_IDX_W-1:0] REG_IN_SIZE_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SIZE_BASE = 4'd4;

    // Per-axis geometry handed to each cell
    typedef struct packed {
        logic [SIZE_W-1:0]  in_size;
        logic [SIZE_W-1:0]  out_size;
        logic [SIZE_W-1:0]  copy;
        logic [COORD_W-1:0] soff;
        logic [COORD_W-1:0] doff;
    } axis_t;

    // Chain-wide control from the top level
    typedef struct packed {
        logic adv;
        logic accept;
        logic restart;
    } ctl_t;

    // Zero acts as one, anything above the max saturates
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_ONE;
        else if (v > MAX_SIZE)
            r = MAX_SIZE;
        else
            r = v;
        return r;
    endfunction

    // Copy size and centering offsets from the two sizes of one axis
    function automatic axis_t axis_params(input logic [SIZE_W-1:0] in_size,
                                          input logic [SIZE_W-1:0] out_size);
        axis_t             a;
        logic [SIZE_W-1:0] half;
        a.in_size  = in_size;
        a.out_size = out_size;
        if (in_size > out_size)
        begin
            half   = (in_size - out_size) >> 1;
            a.soff = half[COORD_W-1:0];
            a.doff = '0;
            a.copy = out_size;
        end
        else
        begin
            half   = (out_size - in_size) >> 1;
            a.soff = '0;
            a.doff = half[COORD_W-1:0];
            a.copy = in_size;
        end
        return a;
    endfunction

endpackage

/* hdl/center_crop_pad_address_gen.sv */
// Centered crop/pad address generator: size registers and a row of axis cells.
// Depends on ccp_pkg and ccp_cell.
//
// Usage: write in_size_0..3 (index 0..3) and out_size_0..3 (index 4..7) through
// cfg_we/cfg_index/cfg_data while no beat is in flight. Each input beat on
// in_valid/in_ready steps a row-major walk over the copy region (restart=1
// starts over at the first element) and yields one output beat carrying the
// source index, destination index and a last flag on the final element.
// Pipeline: one stage per axis cell, each with a multiply-add per index.
// Throughput: one beat per cycle while the chain is not stalled; the
// coordinate counter is a ripple of RANK small digit cells updated at accept.
// Stall: when out_valid is high and out_ready low, the whole cell chain holds
// and in_ready drops in the same cycle; no beat is lost or repeated.
// Reset: all sizes return to 1, the counter to zero and the chain empties.
module center_crop_pad_address_gen #(
    parameter int RANK = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ccp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccp_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ccp_pkg::IDX_W-1:0]         src_index,
    output logic [ccp_pkg::IDX_W-1:0]         dst_index,
    output logic                              last
);
    import ccp_pkg::*;

    logic [SIZE_W-1:0]              in_size_reg  [RANK];
    logic [SIZE_W-1:0]              out_size_reg [RANK];
    logic [RANK-1:0]                in_we;
    logic [RANK-1:0]                out_we;
    axis_t                          axis_cfg [RANK];
    ctl_t                           ctl;

    logic [RANK:0]                  carry;
    logic [RANK-1:0][COORD_W-1:0]   eff_coord;
    logic [RANK:0]                  stg_valid;
    logic [IDX_W-1:0]               stg_si     [RANK+1];
    logic [IDX_W-1:0]               stg_di     [RANK+1];
    logic [RANK:0]                  stg_last;
    logic [RANK-1:0][COORD_W-1:0]   stg_coords [RANK+1];

    // Chain moves when the output slot is empty or being taken
    assign ctl.adv     = !stg_valid[RANK] || out_ready;
    assign in_ready    = ctl.adv;
    assign ctl.accept  = in_valid && ctl.adv;
    assign ctl.restart = restart;

    // Size registers; axes past the register file stay at size 1
    for (genvar d = 0; d < RANK; d++)
    begin : g_size
        if (d < NUM_REG_AXES)
        begin : g_wr
            assign in_we[d]  = cfg_we && (cfg_index == REG_IN_SIZE_BASE + CFG_IDX_W'(d));
            assign out_we[d] = cfg_we && (cfg_index == REG_OUT_SIZE_BASE + CFG_IDX_W'(d));
        end
        else
        begin : g_nowr
            assign in_we[d]  = 1'b0;
            assign out_we[d] = 1'b0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                in_size_reg[d]  <= SIZE_ONE;
                out_size_reg[d] <= SIZE_ONE;
            end
            else
            begin
                if (in_we[d])
                    in_size_reg[d] <= clamp_size(cfg_data);
                if (out_we[d])
                    out_size_reg[d] <= clamp_size(cfg_data);
            end
        end

        assign axis_cfg[d] = axis_params(in_size_reg[d], out_size_reg[d]);
    end

    // Head of the chain: empty accumulators and the current coordinates
    assign carry[RANK]   = 1'b1;
    assign stg_valid[0]  = ctl.accept;
    assign stg_si[0]     = '0;
    assign stg_di[0]     = '0;
    assign stg_last[0]   = 1'b1;
    assign stg_coords[0] = eff_coord;

    // One cell per axis, outermost first
    for (genvar d = 0; d < RANK; d++)
    begin : g_cell
        ccp_cell #(
            .RANK (RANK),
            .AXIS (d)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .axis       (axis_cfg[d]),
            .carry_in   (carry[d+1]),
            .carry_out  (carry[d]),
            .eff_coord  (eff_coord[d]),
            .valid_in   (stg_valid[d]),
            .si_in      (stg_si[d]),
            .di_in      (stg_di[d]),
            .last_in    (stg_last[d]),
            .coords_in  (stg_coords[d]),
            .valid_out  (stg_valid[d+1]),
            .si_out     (stg_si[d+1]),
            .di_out     (stg_di[d+1]),
            .last_out   (stg_last[d+1]),
            .coords_out (stg_coords[d+1])
        );
    end

    // Last cell's stage is the output register
    assign out_valid = stg_valid[RANK];
    assign src_index = stg_si[RANK];
    assign dst_index = stg_di[RANK];
    assign last      = stg_last[RANK] && (carry[0] || !carry[0]);

endmodule

/* hdl/ccp_cell.sv */
// One axis cell: holds that axis's coordinate digit and one stage of the
// index accumulation chain. Depends on ccp_pkg.
module ccp_cell #(
    parameter int RANK = 4,
    parameter int AXIS = 0
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ccp_pkg::ctl_t                             ctl,
    input  ccp_pkg::axis_t                            axis,
    input  logic                                      carry_in,
    output logic                                      carry_out,
    output logic [ccp_pkg::COORD_W-1:0]               eff_coord,
    input  logic                                      valid_in,
    input  logic [ccp_pkg::IDX_W-1:0]                 si_in,
    input  logic [ccp_pkg::IDX_W-1:0]                 di_in,
    input  logic                                      last_in,
    input  logic [RANK-1:0][ccp_pkg::COORD_W-1:0]     coords_in,
    output logic                                      valid_out,
    output logic [ccp_pkg::IDX_W-1:0]                 si_out,
    output logic [ccp_pkg::IDX_W-1:0]                 di_out,
    output logic                                      last_out,
    output logic [RANK-1:0][ccp_pkg::COORD_W-1:0]     coords_out
);
    import ccp_pkg::*;

    logic [COORD_W-1:0]            coord_reg;
    logic [COORD_W-1:0]            coord_next;
    logic [SIZE_W-1:0]             inc;
    logic                          wrap;

    logic                          valid_reg;
    logic [IDX_W-1:0]              si_reg;
    logic [IDX_W-1:0]              di_reg;
    logic                          last_reg;
    logic [RANK-1:0][COORD_W-1:0]  coords_reg;
    logic [IDX_W-1:0]              si_next;
    logic [IDX_W-1:0]              di_next;
    logic                          last_next;
    logic [COORD_W-1:0]            sel;

    // Counter digit: restart clears before use, carry ripples outward
    assign eff_coord = ctl.restart ? '0 : coord_reg;
    assign inc       = {1'b0, eff_coord} + SIZE_ONE;
    assign wrap      = (inc >= axis.copy);
    assign carry_out = carry_in & wrap;

    always_comb
    begin
        if (!carry_in)
            coord_next = eff_coord;
        else if (wrap)
            coord_next = '0;
        else
            coord_next = inc[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coord_reg <= '0;
        else if (ctl.accept)
            coord_reg <= coord_next;
    end

    // Horner step for this axis, wraps mod 2^48
    assign sel       = coords_in[AXIS];
    assign si_next   = si_in * IDX_W'(axis.in_size) + IDX_W'(sel) + IDX_W'(axis.soff);
    assign di_next   = di_in * IDX_W'(axis.out_size) + IDX_W'(sel) + IDX_W'(axis.doff);
    assign last_next = last_in & ({1'b0, sel} == (axis.copy - SIZE_ONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl.adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            si_reg     <= si_next;
            di_reg     <= di_next;
            last_reg   <= last_next;
            coords_reg <= coords_in;
        end
    end

    assign valid_out  = valid_reg;
    assign si_out     = si_reg;
    assign di_out     = di_reg;
    assign last_out   = last_reg;
    assign coords_out = coords_reg;

endmodule

/* tb/ccp_addr_checker.sv */
// Checker for the centered crop/pad address generator: tracks the size registers
// and the coordinate walk, predicts every address beat and compares it at the output.
// Depends on ccp_pkg for widths, size limits and register index bases.
module ccp_addr_checker #(
    parameter int RANK = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ccp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccp_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          restart,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ccp_pkg::IDX_W-1:0]     src_index,
    input  logic [ccp_pkg::IDX_W-1:0]     dst_index,
    input  logic                          last,
    output int                            errors,
    output logic                          busy,
    output int                            n_checked,
    output int                            n_last
);
    timeunit 1ns;
    timeprecision 1ps;

    import ccp_pkg::*;

    localparam int MAX_REPORTS = 25;

    typedef struct packed {
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        logic             fin;
    } addr_beat_t;

    // Shadow of the size registers and the walk position
    logic [SIZE_W-1:0]  in_sz  [RANK];
    logic [SIZE_W-1:0]  out_sz [RANK];
    logic [COORD_W-1:0] pos    [RANK];
    addr_beat_t         addr_q [$];

    // Zero means one; anything past the max saturates
    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return SIZE_ONE;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return v;
    endfunction

    // One step of the walk: form both indices at the current position, then advance
    task automatic walk_step(input logic rs, output addr_beat_t b);
        logic [SIZE_W-1:0] cp [RANK];
        logic [SIZE_W-1:0] s_off;
        logic [SIZE_W-1:0] d_off;
        logic [SIZE_W-1:0] nxt;
        logic [IDX_W-1:0]  si;
        logic [IDX_W-1:0]  di;
        logic              carry;
        if (rs)
        begin
            for (int d = 0; d < RANK; d++)
                pos[d] = '0;
        end
        si    = '0;
        di    = '0;
        b.fin = 1'b1;
        for (int d = 0; d < RANK; d++)
        begin
            // crop offsets the source, pad (or equal) offsets the destination
            if (in_sz[d] > out_sz[d])
            begin
                s_off = (in_sz[d] - out_sz[d]) >> 1;
                d_off = '0;
                cp[d] = out_sz[d];
            end
            else
            begin
                s_off = '0;
                d_off = (out_sz[d] - in_sz[d]) >> 1;
                cp[d] = in_sz[d];
            end
            si = si * in_sz[d] + pos[d] + s_off;
            di = di * out_sz[d] + pos[d] + d_off;
            if ({1'b0, pos[d]} != cp[d] - 1'b1)
                b.fin = 1'b0;
        end
        // row-major increment; a digit at or past its copy size wraps with carry
        carry = 1'b1;
        for (int d = RANK - 1; d >= 0; d--)
        begin
            if (carry)
            begin
                nxt = {1'b0, pos[d]} + 1'b1;
                if (nxt < cp[d])
                begin
                    pos[d] = nxt[COORD_W-1:0];
                    carry  = 1'b0;
                end
                else
                    pos[d] = '0;
            end
        end
        b.src = si;
        b.dst = di;
    endtask

    task automatic flag_field(input string what, input logic [IDX_W-1:0] want_v,
                              input logic [IDX_W-1:0] got_v);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    // Watch config writes, input beats and output beats
    always @(posedge clk or negedge rst_n)
    begin : track
        addr_beat_t want;
        if (!rst_n)
        begin
            for (int d = 0; d < RANK; d++)
            begin
                in_sz[d]  = SIZE_ONE;
                out_sz[d] = SIZE_ONE;
                pos[d]    = '0;
            end
            addr_q.delete();
            errors    = 0;
            n_checked = 0;
            n_last    = 0;
            busy     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < REG_OUT_SIZE_BASE)
                begin
                    if (cfg_index - REG_IN_SIZE_BASE < RANK)
                        in_sz[cfg_index - REG_IN_SIZE_BASE] = sat_size(cfg_data);
                end
                else if (cfg_index < REG_OUT_SIZE_BASE + NUM_REG_AXES)
                begin
                    if (cfg_index - REG_OUT_SIZE_BASE < RANK)
                        out_sz[cfg_index - REG_OUT_SIZE_BASE] = sat_size(cfg_data);
                end
            end

            // output side first so a fresh prediction can never absorb a stray beat
            if (out_valid && out_ready)
            begin
                if (addr_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: unexpected address beat, src %0h dst %0h last %0b",
                                 $time, src_index, dst_index, last);
                end
                else
                begin
                    want = addr_q.pop_front();
                    n_checked++;
                    if (last)
                        n_last++;
                    if (src_index !== want.src)
                        flag_field("src_index", want.src, src_index);
                    if (dst_index !== want.dst)
                        flag_field("dst_index", want.dst, dst_index);
                    if (last !== want.fin)
                        flag_field("last", IDX_W'(want.fin), IDX_W'(last));
                end
            end

            if (in_valid && in_ready)
            begin
                walk_step(restart, want);
                addr_q = {addr_q, want};
            end

            busy <= (addr_q.size() != 0);
        end
    end

endmodule

/* tb/tb_center_crop_pad_address_gen.sv */
// Top of the testbench for center_crop_pad_address_gen: clock, reset, stimulus
// and verdict. Depends on ccp_pkg, the DUT and ccp_addr_checker.
module tb_center_crop_pad_address_gen;
    timeunit 1ns;
    timeprecision 1ps;

    import ccp_pkg::*;

    localparam int RANK          = 4;
    localparam int RAND_ITEMS    = 330;
    localparam int WALK_ITEMS    = 40;
    localparam int SETTLE_CYCLES = RANK + 8;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = REG_OUT_SIZE_BASE + NUM_REG_AXES;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;
    localparam logic [SIZE_W-1:0]    DATA_TOP  = '1;

    typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_ALTERNATE, RX_STARVED} rx_mode_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    val;
    } reg_write_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 restart   = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic [IDX_W-1:0]     src_index;
    logic [IDX_W-1:0]     dst_index;
    logic                 last;

    int   errors;
    int   n_checked;
    int   n_last;
    logic busy;

    int         beats_sent    = 0;
    int         restarts_sent = 0;
    int         settings      = 0;
    int         burst_left    = 0;
    reg_write_t reg_plan [$];
    rx_mode_t   rx_mode       = RX_OPEN;
    int         rx_hold       = 0;

    center_crop_pad_address_gen #(
        .RANK(RANK)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .src_index(src_index),
        .dst_index(dst_index),
        .last     (last)
    );

    ccp_addr_checker #(
        .RANK(RANK)
    ) chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .src_index(src_index),
        .dst_index(dst_index),
        .last     (last),
        .errors   (errors),
        .busy     (busy),
        .n_checked(n_checked),
        .n_last   (n_last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Receiver: switches between open, choppy, alternating and starved stretches
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 160);
        end
        else
            rx_hold <= rx_hold - 1;
        case (rx_mode)
            RX_OPEN:      out_ready <= 1'b1;
            RX_CHOPPY:    out_ready <= ($urandom_range(0, 3) != 0);
            RX_ALTERNATE: out_ready <= ~out_ready;
            RX_STARVED:   out_ready <= ($urandom_range(0, 5) == 0);
            default:      out_ready <= 1'b1;
        endcase
    end

    // Mostly small sizes so walks finish; some near the max, zero and oversize
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return SIZE_W'($urandom_range(1, 3));
        if (r < 68)
            return '0;
        if (r < 78)
            return SIZE_W'($urandom_range(4090, 4096));
        if (r < 86)
            return SIZE_W'($urandom_range(4097, DATA_TOP));
        return SIZE_W'($urandom_range(0, DATA_TOP));
    endfunction

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        reg_write_t w;
        w.idx = idx;
        w.val = val;
        reg_plan = {reg_plan, w};
    endtask

    task automatic plan_axis(input int axis, input logic [SIZE_W-1:0] isz,
                             input logic [SIZE_W-1:0] osz);
        plan_reg(CFG_IDX_W'(REG_IN_SIZE_BASE + axis), isz);
        plan_reg(CFG_IDX_W'(REG_OUT_SIZE_BASE + axis), osz);
    endtask

    // Issue the planned register writes back to back; caller makes sure the DUT is idle
    task automatic apply_plan();
        if (reg_plan.size() != 0)
        begin
            foreach (reg_plan[i])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= reg_plan[i].idx;
                cfg_data  <= reg_plan[i].val;
                @(posedge clk);
            end
            cfg_we <= 1'b0;
            reg_plan.delete();
            settings++;
        end
    endtask

    // Send one beat; bursts of random length with random gaps between them
    task automatic push_item(input logic rs);
        int gap;
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (rs)
            restarts_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Stop sending and wait until every predicted beat has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int rand_beats;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: every beat is the single, last element at index zero
        push_item(1'b0);
        push_item(1'b0);
        drain();

        // Deepest crop on every axis
        for (int a = 0; a < NUM_REG_AXES; a++)
            plan_axis(a, MAX_SIZE, SIZE_ONE);
        apply_plan();
        push_item(1'b1);
        push_item(1'b0);
        drain();

        // Deepest pad on every axis
        for (int a = 0; a < NUM_REG_AXES; a++)
            plan_axis(a, SIZE_ONE, MAX_SIZE);
        apply_plan();
        push_item(1'b0);
        drain();

        // Zero and oversize values saturate; indices past the last register are ignored
        plan_axis(0, '0, DATA_TOP);
        plan_axis(1, DATA_TOP, '0);
        plan_axis(2, SIZE_W'(4097), SIZE_W'(2));
        plan_axis(3, SIZE_W'(3), SIZE_ONE);
        plan_reg(REG_LIMIT, SIZE_W'(5));
        plan_reg(REG_TOP, SIZE_W'('h1555));
        plan_reg(CFG_IDX_W'(REG_LIMIT + 1), '0);
        apply_plan();
        push_item(1'b1);
        push_item(1'b0);
        push_item(1'b0);
        drain();

        // Small mixed crop/pad, restart part way through a walk
        plan_axis(0, SIZE_W'(2), SIZE_W'(3));
        plan_axis(1, SIZE_W'(3), SIZE_W'(2));
        plan_axis(2, SIZE_ONE, SIZE_ONE);
        plan_axis(3, SIZE_W'(5), SIZE_W'(2));
        apply_plan();
        for (int i = 0; i < 9; i++)
            push_item(i == 0 || i == 5);
        drain();

        // Shrink mid-walk: coordinates left beyond the new copy size
        plan_reg(CFG_IDX_W'(REG_OUT_SIZE_BASE + 3), SIZE_ONE);
        plan_reg(REG_OUT_SIZE_BASE, SIZE_ONE);
        apply_plan();
        for (int i = 0; i < 3; i++)
            push_item(1'b0);
        drain();

        // Largest tensor on both sides
        for (int a = 0; a < NUM_REG_AXES; a++)
            plan_axis(a, MAX_SIZE, MAX_SIZE);
        apply_plan();
        push_item(1'b1);
        push_item(1'b0);
        drain();

        // Walk along the outer axis, then shrink it so that coordinate sits past its copy size
        plan_axis(0, MAX_SIZE, MAX_SIZE);
        for (int a = 1; a < NUM_REG_AXES; a++)
            plan_axis(a, SIZE_ONE, SIZE_ONE);
        apply_plan();
        for (int i = 0; i < WALK_ITEMS; i++)
            push_item(i == 0);
        drain();
        plan_reg(REG_OUT_SIZE_BASE, SIZE_ONE);
        for (int a = 1; a < NUM_REG_AXES; a++)
            plan_axis(a, MAX_SIZE, MAX_SIZE);
        apply_plan();
        for (int i = 0; i < 6; i++)
            push_item(1'b0);
        drain();

        // Random settings, each followed by a stretch of walk beats
        rand_beats = 0;
        while (rand_beats < RAND_ITEMS)
        begin
            for (int a = 0; a < NUM_REG_AXES; a++)
            begin
                if ($urandom_range(0, 3) != 0)
                    plan_reg(CFG_IDX_W'(REG_IN_SIZE_BASE + a), pick_size());
                if ($urandom_range(0, 3) != 0)
                    plan_reg(CFG_IDX_W'(REG_OUT_SIZE_BASE + a), pick_size());
            end
            if ($urandom_range(0, 3) == 0)
                plan_reg(CFG_IDX_W'($urandom_range(REG_LIMIT, REG_TOP)),
                         SIZE_W'($urandom_range(0, DATA_TOP)));
            apply_plan();
            n = $urandom_range(15, 50);
            for (int i = 0; i < n; i++)
            begin
                if (i == 0)
                    push_item($urandom_range(0, 1) == 1);
                else
                    push_item($urandom_range(0, 15) == 0);
                rand_beats++;
            end
            drain();
        end

        // Let the pipeline settle so any stray beat shows up
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d input beats (%0d with restart) across %0d register settings.",
                 beats_sent, restarts_sent, settings);
        $display("Checked %0d address beats, %0d of them on the last element.",
                 n_checked, n_last);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the DUT.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
